>>> rtl/core/ols_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_pkg
// Shared widths, operation and status codes, sequencer states and the
// control bundle that steps the chain of entry cells.
// ----------------------------------------------------------------------------
package ols_pkg;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int RES_W  = 37;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SUM    = 3'd2;
  localparam logic [OP_W-1:0] OP_MIN    = 3'd3;
  localparam logic [OP_W-1:0] OP_PRINT  = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INDEX = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  // one step of the cell chain
  typedef struct packed {
    logic load;   // write the load value into the addressed cell
    logic shift;  // every cell takes its right neighbor (the last cell keeps its own)
    logic wrap;   // tail cell takes the head instead (ring rotation)
  } chain_ctl_t;

endpackage : ols_pkg
`default_nettype wire

>>> rtl/core/ols_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_if
// Valid/ready channels of the list store: operation in, result items out.
// ----------------------------------------------------------------------------
interface ols_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] item_value;
  logic [7:0]         position;

  modport source (output valid, output op, output item_value, output position,
                  input ready);
  modport sink   (input valid, input op, input item_value, input position,
                  output ready);
endinterface : ols_in_if

interface ols_out_if;
  logic               valid;
  logic               ready;
  logic signed [36:0] result_value;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output result_value, output status, output last,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last,
                  output ready);
endinterface : ols_out_if
`default_nettype wire

>>> rtl/core/ols_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_cell
// One list entry: loads a new value, or takes its right neighbor or the
// chain head when the chain steps.
// ----------------------------------------------------------------------------
module ols_cell
  import ols_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    load_here,
  input  wire logic                    shift,
  input  wire logic                    wrap_here,
  input  wire logic signed [VAL_W-1:0] load_data,
  input  wire logic signed [VAL_W-1:0] from_next,
  input  wire logic signed [VAL_W-1:0] from_head,
  output      logic signed [VAL_W-1:0] q
);

  logic signed [VAL_W-1:0] q_r;
  logic signed [VAL_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (load_here) begin
      q_nxt = load_data;
    end else if (shift) begin
      q_nxt = wrap_here ? from_head : from_next;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule : ols_cell
`default_nettype wire

>>> rtl/core/ols_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ols_chain
// Row of entry cells. Cell 0 is the head; a step moves every entry one
// place toward the head and, with wrap set, moves the head to the tail cell.
// ----------------------------------------------------------------------------
module ols_chain
  import ols_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic                          clk,
  input  wire chain_ctl_t                    ctl,
  input  wire logic [$clog2(CAPACITY)-1:0]   tail_idx,
  input  wire logic [$clog2(CAPACITY)-1:0]   load_idx,
  input  wire logic signed [VAL_W-1:0]       load_data,
  output      logic signed [VAL_W-1:0]       head
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic signed [VAL_W-1:0] q [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] nb;
    if (i == CAPACITY - 1) begin : g_end
      assign nb = q[i];
    end else begin : g_mid
      assign nb = q[i+1];
    end

    ols_cell u_cell (
      .clk       (clk),
      .load_here (ctl.load && (IDX_W'(i) == load_idx)),
      .shift     (ctl.shift),
      .wrap_here (ctl.wrap && (IDX_W'(i) == tail_idx)),
      .load_data (load_data),
      .from_next (nb),
      .from_head (q[0]),
      .q         (q[i])
    );
  end

  assign head = q[0];

endmodule : ols_chain
`default_nettype wire

>>> rtl/core/ordered_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered list of signed 32-bit entries kept in insertion order in a ring
// of cells, with append, delete, sum, minimum-from-position and print.
// ----------------------------------------------------------------------------
// One operation is taken at a time. Every list walk rotates the cell chain
// once around its filled length, one entry past the head cell per cycle
// (a print walk holds while its listed entry has nowhere to go), so the
// cost is set by the entry count n. Print lists every entry, each waiting
// for the result side to take it; append writes its entry on accept, then
// lists the whole list. Sum, minimum and delete end in a single result;
// delete drops the entry from the ring during that same rotation, which
// closes the gap. Error, empty and full cases skip the walk. A new operation
// is taken while the final result still waits in the output register.
// There is no clearing pass: cells are read only after being written.
// ----------------------------------------------------------------------------
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ols_in_if.sink      in_if,
  ols_out_if.source   out_if
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int EXT_W = RES_W - VAL_W;

  // sequencer state
  state_t                  state_r, state_nxt;
  logic [OP_W-1:0]         mode_r, mode_nxt;    // walk type
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;  // valid entries
  logic [CNT_W-1:0]        len_r, len_nxt;      // ring length during a walk
  logic [CNT_W-1:0]        k_r, k_nxt;          // list index now at the head
  logic signed [RES_W-1:0] res_r, res_nxt;      // sum, minimum or removed value
  logic [STAT_W-1:0]       stat_r, stat_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0] out_val_r, out_val_nxt;
  logic [STAT_W-1:0]       out_stat_r, out_stat_nxt;
  logic                    out_last_r, out_last_nxt;

  chain_ctl_t              ctl;
  logic signed [VAL_W-1:0] head;
  logic signed [RES_W-1:0] head_ext;
  logic [CNT_W-1:0]        tail_full;
  logic [CNT_W-1:0]        last_k;
  logic                    out_free;
  logic                    step;
  logic                    is_last;
  logic                    drop;
  logic                    out_load;

  ols_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .tail_idx  (tail_full[IDX_W-1:0]),
    .load_idx  (count_r[IDX_W-1:0]),
    .load_data (in_if.item_value),
    .head      (head)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign tail_full   = len_r - CNT_W'(1);
  assign last_k      = count_r - CNT_W'(1);
  assign head_ext    = {{EXT_W{head[VAL_W-1]}}, head};
  assign out_free    = !out_valid_r || out_if.ready;
  // a print walk only advances when its listed entry has somewhere to go
  assign step        = (state_r == S_SCAN) && ((mode_r != OP_PRINT) || out_free);
  assign is_last     = (k_r == last_k);
  assign drop        = (mode_r == OP_DELETE) && (POS_W'(k_r) == pos_r);

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    k_nxt        = k_r;
    res_nxt      = res_r;
    stat_nxt     = stat_r;
    out_load     = 1'b0;
    out_val_nxt  = out_val_r;
    out_stat_nxt = out_stat_r;
    out_last_nxt = out_last_r;
    ctl          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          pos_nxt  = in_if.position;
          mode_nxt = in_if.op;
          k_nxt    = '0;
          len_nxt  = count_r;
          res_nxt  = '0;
          stat_nxt = STAT_OK;
          case (in_if.op)
            OP_APPEND: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                stat_nxt  = STAT_FULL;
                state_nxt = S_RESULT;
              end else begin
                // write at the end, then list everything
                ctl.load  = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                len_nxt   = count_r + CNT_W'(1);
                mode_nxt  = OP_PRINT;
                state_nxt = S_SCAN;
              end
            end
            OP_DELETE, OP_MIN: begin
              if (in_if.position >= POS_W'(count_r)) begin
                stat_nxt  = STAT_INDEX;
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_SUM: begin
              state_nxt = (count_r == '0) ? S_RESULT : S_SCAN;
            end
            OP_PRINT: begin
              if (count_r == '0) begin
                stat_nxt  = STAT_EMPTY;
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused codes: no result, no change
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (step) begin
          ctl.shift = 1'b1;
          ctl.wrap  = !drop;  // a dropped entry is not wrapped to the tail
          k_nxt     = k_r + CNT_W'(1);
          case (mode_r)
            OP_PRINT: begin
              out_load     = 1'b1;
              out_val_nxt  = head_ext;
              out_stat_nxt = STAT_OK;
              out_last_nxt = is_last;
            end
            OP_SUM: begin
              res_nxt = res_r + head_ext;
            end
            OP_MIN: begin
              if ((POS_W'(k_r) == pos_r) ||
                  ((POS_W'(k_r) > pos_r) && (head < $signed(res_r[VAL_W-1:0])))) begin
                res_nxt = head_ext;
              end
            end
            OP_DELETE: begin
              if (drop) begin
                res_nxt = head_ext;
                len_nxt = len_r - CNT_W'(1);
              end
            end
            default: begin
              res_nxt = res_r;
            end
          endcase
          if (is_last) begin
            if (mode_r == OP_PRINT) begin
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_RESULT;
              if (mode_r == OP_DELETE) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
          end
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_val_nxt  = res_r;
          out_stat_nxt = stat_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    pos_r      <= pos_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_value = out_val_r;
  assign out_if.status       = out_stat_r;
  assign out_if.last         = out_last_r;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_walk_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r < count_r))
    else $error("walk index past the filled length");

  a_delete_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_last && (mode_r == OP_DELETE)) |=>
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete walk did not shrink the list");

  a_out_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_valid_r) |-> out_if.ready)
    else $error("result register overwritten before transaction");
`endif

endmodule : ordered_list_store
`default_nettype wire

>>> tb/sv/ordered_list_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_checker
// Watches both channels of the list store, keeps its own copy of the list,
// predicts the result transactions of every accepted operation and compares
// them in order with the ones the block hands out.
// ----------------------------------------------------------------------------
module ordered_list_store_checker
  import ols_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst_n,
  ols_in_if    in_ch,
  ols_out_if   out_ch,
  output int   mismatches,
  output int   pending_results,
  output int   results_checked
);

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic                    last;
  } list_result_t;

  logic signed [VAL_W-1:0] list_entries [CAPACITY];
  int                      list_len       = 0;
  list_result_t            awaited_results [$];
  int                      mismatch_total = 0;
  int                      checked_total  = 0;
  int                      awaited_now    = 0;

  assign mismatches      = mismatch_total;
  assign pending_results = awaited_now;
  assign results_checked = checked_total;

  function automatic logic signed [RES_W-1:0] widen(input logic signed [VAL_W-1:0] v);
    return {{(RES_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_total++;
  endtask

  task automatic push_result(input logic signed [RES_W-1:0] value,
                             input logic [STAT_W-1:0] status, input logic last);
    list_result_t r;
    r.value  = value;
    r.status = status;
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  task automatic push_listing();
    if (list_len == 0) begin
      push_result('0, STAT_EMPTY, 1'b1);
    end else begin
      for (int i = 0; i < list_len; i++)
        push_result(widen(list_entries[i]), STAT_OK, i == list_len - 1);
    end
  endtask

  task automatic apply_list_op(input logic [OP_W-1:0] op,
                               input logic signed [VAL_W-1:0] value,
                               input logic [POS_W-1:0] pos);
    logic signed [RES_W-1:0] total;
    logic signed [VAL_W-1:0] low;
    int                      p;
    p = int'(pos);
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          push_result('0, STAT_FULL, 1'b1);
        end else begin
          list_entries[list_len] = value;
          list_len++;
          push_listing();
        end
      end
      OP_DELETE: begin
        if (p >= list_len) begin
          push_result('0, STAT_INDEX, 1'b1);
        end else begin
          push_result(widen(list_entries[p]), STAT_OK, 1'b1);
          for (int i = p; i < list_len - 1; i++)
            list_entries[i] = list_entries[i + 1];
          list_len--;
        end
      end
      OP_SUM: begin
        total = '0;
        for (int i = 0; i < list_len; i++)
          total = total + widen(list_entries[i]);
        push_result(total, STAT_OK, 1'b1);
      end
      OP_MIN: begin
        if (p >= list_len) begin
          push_result('0, STAT_INDEX, 1'b1);
        end else begin
          low = list_entries[p];
          for (int i = p + 1; i < list_len; i++)
            if (list_entries[i] < low) low = list_entries[i];
          push_result(widen(low), STAT_OK, 1'b1);
        end
      end
      OP_PRINT: push_listing();
      default: ;  // unused codes: no result, list untouched
    endcase
  endtask

  task automatic check_result();
    list_result_t want;
    if (awaited_results.size() == 0) begin
      report($sformatf("unexpected result value=%0d status=%0d last=%0b",
                       out_ch.result_value, out_ch.status, out_ch.last));
      return;
    end
    want = awaited_results.pop_front();
    checked_total++;
    if (out_ch.result_value !== want.value)
      report($sformatf("result_value got %0d want %0d", out_ch.result_value, want.value));
    if (out_ch.status !== want.status)
      report($sformatf("status got %0d want %0d", out_ch.status, want.status));
    if (out_ch.last !== want.last)
      report($sformatf("last got %0b want %0b", out_ch.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      list_len = 0;
    end else begin
      // results first: a result taken at this edge never belongs to the
      // operation taken at the same edge
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready)
        apply_list_op(in_ch.op, in_ch.item_value, in_ch.position);
    end
    awaited_now = awaited_results.size();
  end

endmodule : ordered_list_store_checker

>>> tb/sv/ordered_list_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_tb
// Drives operations into the list store and throttles its result side;
// the checker beside the block predicts and compares every transaction.
// ----------------------------------------------------------------------------
module ordered_list_store_tb;
  import ols_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 500_000;
  // longest list walk plus the write and output stages, with margin
  localparam int TAIL_CYCLES  = 2 * CAPACITY + 16;
  localparam int PHASE_OPS    = 45;

  // codes 5..7 carry no operation; the block must ignore them
  localparam logic [OP_W-1:0]         OP_RESERVED = 3'd5;
  localparam logic signed [VAL_W-1:0] VAL_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN     = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle_pct;
  int recv_idle_pct;
  int list_len;      // shadow of the list length, only to shape stimulus
  int full_hits;     // appends sent while the list was full
  int full_streak;   // same, since the list last started growing
  int ops_sent;
  int cycle_count;
  bit grow;

  int mismatches;
  int pending_results;
  int results_checked;

  ols_in_if  in_ch  ();
  ols_out_if out_ch ();

  ordered_list_store #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  ordered_list_store_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always #CLK_HALF clk = ~clk;

  // Result side backpressure: one decision per cycle, at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one operation. Called and returning just after a falling edge;
  // valid stays high on return so back-to-back transactions have no bubble.
  task automatic send_op(input logic [OP_W-1:0] op,
                         input logic signed [VAL_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.op         = op;
    in_ch.item_value = value;
    in_ch.position   = pos;
    do @(posedge clk); while (!in_ch.ready);
    // transaction taken at this edge; keep the shadow length in step
    case (op)
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_len++;
        end else begin
          full_hits++;
          full_streak++;
        end
      end
      OP_DELETE: if (int'(pos) < list_len) list_len--;
      default: ;
    endcase
    if (op <= OP_PRINT) ops_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every predicted result has come out.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // Random operations. The mix swings between growing the list until a few
  // appends bounce off a full list and shrinking it back to one entry, so
  // long listings, full, index and empty cases all come up.
  task automatic run_random_ops(input int count);
    int                      done;
    int                      r;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    done = 0;
    while (done < count) begin
      if (grow && list_len == CAPACITY && full_streak >= 2) begin
        grow = 1'b0;
      end else if (!grow && list_len <= 1) begin
        grow        = 1'b1;
        full_streak = 0;
      end

      r = $urandom_range(99);
      if (r < 3)
        op = OP_RESERVED + OP_W'($urandom_range(2));
      else if (grow)
        op = (r < 73) ? OP_APPEND : (r < 78) ? OP_DELETE : (r < 85) ? OP_SUM :
             (r < 93) ? OP_MIN : OP_PRINT;
      else
        op = (r < 13) ? OP_APPEND : (r < 63) ? OP_DELETE : (r < 73) ? OP_SUM :
             (r < 88) ? OP_MIN : OP_PRINT;

      case ($urandom_range(9))
        0:       value = VAL_MAX;
        1:       value = VAL_MIN;
        2:       value = '0;
        3:       value = -1;
        4:       value = VAL_W'($urandom_range(20)) - 10;
        default: value = $urandom;
      endcase

      case ($urandom_range(9))
        0:       pos = '0;
        1:       pos = POS_W'(list_len);           // one past the end
        2:       pos = '1;
        3:       pos = POS_W'($urandom);
        4:       pos = (list_len > 0) ? POS_W'(list_len - 1) : '0;
        default: pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1))
                                      : POS_W'($urandom);
      endcase

      send_op(op, value, pos);
      if (op <= OP_PRINT) done++;
    end
  endtask

  // Run watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still awaited",
             cycle_count, pending_results);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_SUM;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    send_idle_pct    = 20;
    recv_idle_pct    = 67;
    list_len         = 0;
    full_hits        = 0;
    full_streak      = 0;
    ops_sent         = 0;
    grow             = 1'b1;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed: empty list first ---
    send_op(OP_PRINT,  '0, '0);                  // empty status
    send_op(OP_SUM,    '0, '0);                  // sum of nothing is 0
    send_op(OP_DELETE, '0, '0);                  // index error on empty list
    send_op(OP_MIN,    '0, '0);
    // unused codes with every payload bit set: must be dropped silently
    send_op(OP_RESERVED,                  '1, '1);
    send_op(OP_RESERVED + OP_W'(1),       '1, '1);
    send_op(OP_RESERVED + OP_W'(2),       '1, '1);
    // value extremes, each append lists the whole list back
    send_op(OP_APPEND, VAL_MAX, '1);
    send_op(OP_APPEND, VAL_MIN, '0);
    send_op(OP_APPEND, '0,      '0);
    send_op(OP_APPEND, -1,      '0);
    send_op(OP_APPEND, 1,       '0);
    send_op(OP_SUM,    '0, '0);
    send_op(OP_MIN,    '0, 8'd0);                // whole list
    send_op(OP_MIN,    '0, 8'd4);                // tail entry alone
    send_op(OP_MIN,    '0, 8'd5);                // one past the end
    send_op(OP_MIN,    '0, 8'd255);
    send_op(OP_DELETE, '0, 8'd255);
    send_op(OP_DELETE, '0, 8'd2);                // middle: later entries close up
    send_op(OP_DELETE, '0, 8'd3);                // tail
    send_op(OP_DELETE, '0, 8'd0);                // head
    send_op(OP_PRINT,  '0, '0);
    send_op(OP_SUM,    '0, '0);

    // --- random: three idling regimes, sender drained between them ---
    run_random_ops(PHASE_OPS);
    wait_drained();
    send_idle_pct = 67;
    recv_idle_pct = 20;
    run_random_ops(PHASE_OPS);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_ops(PHASE_OPS);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d operations and %0d checked results; %0d appends hit a full list",
             ops_sent, results_checked, full_hits);
    $display("idling: sender 20%%/receiver 67%%, then 67%%/20%%, then none; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : ordered_list_store_tb
